// ===== rtl/tcc_pkg.sv =====
// Package for the table connected convolution block.
// Holds store bounds, field widths, operation and status codes.
// No dependencies.
`default_nettype none
package tcc_pkg;
    localparam int MAX_IN_PLANES_D  = 8;
    localparam int MAX_OUT_PLANES_D = 16;
    localparam int MAX_DIM_D        = 32;
    localparam int MAX_KERNEL_D     = 8;
    localparam int MAX_TABLE_D      = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [2:0] {
        OP_PIXEL = 3'd0,
        OP_WEIGHT = 3'd1,
        OP_TABLE = 3'd2,
        OP_BIAS = 3'd3,
        OP_READ = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT = 3'd0,
        CFG_IN_WIDTH = 3'd1,
        CFG_KERNEL_HEIGHT = 3'd2,
        CFG_KERNEL_WIDTH = 3'd3,
        CFG_TABLE_ENTRIES = 3'd4,
        CFG_OUT_PLANES = 3'd5
    } t_cfg_idx;
endpackage
`default_nettype wire

// ===== rtl/table_connected_convolution.sv =====
// Top level of the table connected convolution block: stores and read sequencer.
// Depends on tcc_pkg and tcc_ram.
//
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_op .. i_value
// out      output     o_out_valid / i_out_ready   o_out_value, o_status
// cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A write item is answered straight from the idle state. A read item loads the
// bias, then per table entry checks the connection and, for an entry that targets
// the plane, runs a pipelined multiply-accumulate over the kh*kw pixel and weight taps.
// One item is in work at a time; the next is taken once the result is stored.
// Reset is synchronous and active low; the stores are not cleared.
`default_nettype none
module table_connected_convolution
    import tcc_pkg::*;
#(
    parameter int MAX_IN_PLANES  = MAX_IN_PLANES_D,
    parameter int MAX_OUT_PLANES = MAX_OUT_PLANES_D,
    parameter int MAX_DIM        = MAX_DIM_D,
    parameter int MAX_KERNEL     = MAX_KERNEL_D,
    parameter int MAX_TABLE      = MAX_TABLE_D
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [2:0]            i_op,
    input  wire logic [5:0]            i_entry,
    input  wire logic [2:0]            i_in_plane,
    input  wire logic [3:0]            i_out_plane,
    input  wire logic [4:0]            i_row,
    input  wire logic [4:0]            i_col,
    input  wire logic signed [31:0]    i_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [31:0]         o_out_value,
    output logic [1:0]                 o_status,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int PIX_DEPTH  = MAX_IN_PLANES * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH  = MAX_TABLE * MAX_KERNEL * MAX_KERNEL;
    localparam int PIX_AW     = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int CONN_AW    = (MAX_TABLE > 1) ? $clog2(MAX_TABLE) : 1;
    localparam int BIAS_AW    = (MAX_OUT_PLANES > 1) ? $clog2(MAX_OUT_PLANES) : 1;
    localparam int ACC_W      = 34 + $clog2(WGT_DEPTH + 1);
    localparam logic [PIX_AW-1:0] DIM_A  = PIX_AW'(MAX_DIM);
    localparam logic [WGT_AW-1:0] KER_A  = WGT_AW'(MAX_KERNEL);
    localparam logic [WGT_AW-1:0] KK_A   = WGT_AW'(MAX_KERNEL * MAX_KERNEL);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-32){1'b1}}, 32'h80000000};

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BIAS  = 6'b000010,
        S_CONN  = 6'b000100,
        S_MAC   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    logic [5:0] r_in_height, r_in_width;
    logic [3:0] r_kernel_height, r_kernel_width;
    logic [6:0] r_table_entries;
    logic [4:0] r_out_planes;

    logic [5:0] ih, iw;
    logic [3:0] kh, kw;
    logic [6:0] ne;
    logic [4:0] np;

    logic [3:0] r_plane;
    logic [4:0] r_row, r_col;
    logic [2:0] r_src;
    logic [6:0] r_e;
    logic [3:0] r_i, r_j;
    logic       r_rd_v, r_prod_v;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic in_acc, out_free, rd_bad;
    logic sat16_hi, sat16_lo;
    logic signed [15:0] val16;

    logic pix_we, wgt_we, conn_we, bias_we;
    logic [PIX_AW-1:0] pix_waddr, pix_raddr;
    logic [WGT_AW-1:0] wgt_waddr, wgt_raddr;
    logic [CONN_AW-1:0] conn_waddr, conn_raddr;
    logic [BIAS_AW-1:0] bias_waddr, bias_raddr;
    logic signed [15:0] pix_q, wgt_q;
    logic [6:0]  conn_q;
    logic signed [31:0] bias_q;
    logic [2:0] conn_src;
    logic [3:0] conn_dst;
    logic conn_hit, last_tap, last_entry;

    always_comb begin
        ih = (r_in_height == '0) ? 6'd1 :
             (int'(r_in_height) > MAX_DIM) ? 6'(MAX_DIM) : r_in_height;
        iw = (r_in_width == '0) ? 6'd1 :
             (int'(r_in_width) > MAX_DIM) ? 6'(MAX_DIM) : r_in_width;
        kh = (r_kernel_height == '0) ? 4'd1 :
             (int'(r_kernel_height) > MAX_KERNEL) ? 4'(MAX_KERNEL) : r_kernel_height;
        kw = (r_kernel_width == '0) ? 4'd1 :
             (int'(r_kernel_width) > MAX_KERNEL) ? 4'(MAX_KERNEL) : r_kernel_width;
        ne = (int'(r_table_entries) > MAX_TABLE) ? 7'(MAX_TABLE) : r_table_entries;
        np = (r_out_planes == '0) ? 5'd1 :
             (int'(r_out_planes) > MAX_OUT_PLANES) ? 5'(MAX_OUT_PLANES) : r_out_planes;
    end

    assign out_free    = !o_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    assign rd_bad = (kh > 4'(ih) && ih < 6'd16) || (6'(kh) > ih) || (6'(kw) > iw) ||
                    (5'(i_out_plane) >= np) ||
                    (7'(i_row) > (7'(ih) - 7'(kh))) ||
                    (7'(i_col) > (7'(iw) - 7'(kw)));

    assign sat16_hi = i_value > 32'sd32767;
    assign sat16_lo = i_value < -32'sd32768;
    assign val16 = sat16_hi ? 16'sd32767 : sat16_lo ? -16'sd32768 : i_value[15:0];

    always_comb begin
        pix_we  = 1'b0;
        wgt_we  = 1'b0;
        conn_we = 1'b0;
        bias_we = 1'b0;
        if (in_acc) begin
            unique case (i_op)
                OP_PIXEL:  pix_we  = (int'(i_in_plane) < MAX_IN_PLANES) &&
                                     (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
                OP_WEIGHT: wgt_we  = (int'(i_entry) < MAX_TABLE) &&
                                     (int'(i_row) < MAX_KERNEL) &&
                                     (int'(i_col) < MAX_KERNEL);
                OP_TABLE:  conn_we = (int'(i_entry) < MAX_TABLE) &&
                                     (int'(i_in_plane) < MAX_IN_PLANES) &&
                                     (int'(i_out_plane) < MAX_OUT_PLANES);
                OP_BIAS:   bias_we = int'(i_out_plane) < MAX_OUT_PLANES;
                default: ;
            endcase
        end
    end

    assign pix_waddr = (PIX_AW'(i_in_plane) * DIM_A + PIX_AW'(i_row)) * DIM_A +
                       PIX_AW'(i_col);
    assign wgt_waddr = WGT_AW'(i_entry) * KK_A + WGT_AW'(i_row) * KER_A + WGT_AW'(i_col);
    assign conn_waddr = CONN_AW'(i_entry);
    assign bias_waddr = BIAS_AW'(i_out_plane);

    assign pix_raddr = (PIX_AW'(r_src) * DIM_A + PIX_AW'(r_row) + PIX_AW'(r_i)) * DIM_A +
                       PIX_AW'(r_col) + PIX_AW'(r_j);
    assign wgt_raddr = WGT_AW'(r_e) * KK_A + WGT_AW'(r_i) * KER_A + WGT_AW'(r_j);
    assign conn_raddr = (r_state == S_BIAS) ? '0 : CONN_AW'(r_e + 7'd1);
    assign bias_raddr = BIAS_AW'(i_out_plane);

    assign conn_src   = conn_q[2:0];
    assign conn_dst   = conn_q[6:3];
    assign conn_hit   = (conn_dst == r_plane) && (int'(conn_src) < MAX_IN_PLANES);
    assign last_tap   = (r_i == kh - 4'd1) && (r_j == kw - 4'd1);
    assign last_entry = (r_e + 7'd1) >= ne;

    tcc_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH), .AW(PIX_AW)) u_pix (
        .i_clk(i_clk), .i_we(pix_we), .i_waddr(pix_waddr), .i_wdata(val16),
        .i_raddr(pix_raddr), .o_rdata(pix_q)
    );
    tcc_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH), .AW(WGT_AW)) u_wgt (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(wgt_waddr), .i_wdata(val16),
        .i_raddr(wgt_raddr), .o_rdata(wgt_q)
    );
    tcc_ram #(.WIDTH(7), .DEPTH(MAX_TABLE), .AW(CONN_AW)) u_conn (
        .i_clk(i_clk), .i_we(conn_we), .i_waddr(conn_waddr),
        .i_wdata({i_out_plane, i_in_plane}), .i_raddr(conn_raddr), .o_rdata(conn_q)
    );
    tcc_ram #(.WIDTH(32), .DEPTH(MAX_OUT_PLANES), .AW(BIAS_AW)) u_bias (
        .i_clk(i_clk), .i_we(bias_we), .i_waddr(bias_waddr), .i_wdata(i_value),
        .i_raddr(bias_raddr), .o_rdata(bias_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height     <= 6'd32;
            r_in_width      <= 6'd32;
            r_kernel_height <= 4'd5;
            r_kernel_width  <= 4'd5;
            r_table_entries <= 7'd0;
            r_out_planes    <= 5'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IN_HEIGHT:     r_in_height     <= i_cfg_data[5:0];
                CFG_IN_WIDTH:      r_in_width      <= i_cfg_data[5:0];
                CFG_KERNEL_HEIGHT: r_kernel_height <= i_cfg_data[3:0];
                CFG_KERNEL_WIDTH:  r_kernel_width  <= i_cfg_data[3:0];
                CFG_TABLE_ENTRIES: r_table_entries <= i_cfg_data[6:0];
                CFG_OUT_PLANES:    r_out_planes    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= pix_q * wgt_q;
        if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_BIAS) begin
            r_acc <= ACC_W'(bias_q);
        end
        if (in_acc) begin
            r_plane <= i_out_plane;
            r_row   <= i_row;
            r_col   <= i_col;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
        end else begin
            r_rd_v   <= (r_state == S_MAC);
            r_prod_v <= r_rd_v;
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        o_out_value <= '0;
                        if (i_op == OP_READ) begin
                            if (rd_bad) begin
                                o_out_valid <= 1'b1;
                                o_status    <= ST_RANGE;
                            end else begin
                                r_state <= S_BIAS;
                            end
                        end else begin
                            o_out_valid <= 1'b1;
                            o_status <= (pix_we || wgt_we || conn_we || bias_we) ?
                                        ST_OK : ST_RANGE;
                        end
                    end
                end
                S_BIAS: begin
                    r_e <= '0;
                    r_state <= (ne == '0) ? S_DONE : S_CONN;
                end
                S_CONN: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (conn_hit) begin
                        r_src   <= conn_src;
                        r_state <= S_MAC;
                    end else if (last_entry) begin
                        r_state <= S_DONE;
                    end else begin
                        r_e <= r_e + 7'd1;
                    end
                end
                S_MAC: begin
                    if (last_tap) begin
                        r_state <= S_DRAIN;
                    end else if (r_j == kw - 4'd1) begin
                        r_j <= '0;
                        r_i <= r_i + 4'd1;
                    end else begin
                        r_j <= r_j + 4'd1;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_v && !r_prod_v) begin
                        if (last_entry) begin
                            r_state <= S_DONE;
                        end else begin
                            r_e     <= r_e + 7'd1;
                            r_state <= S_CONN;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_acc > ACC_MAX) begin
                            o_out_value <= 32'sh7fffffff;
                            o_status    <= ST_SAT;
                        end else if (r_acc < ACC_MIN) begin
                            o_out_value <= 32'sh80000000;
                            o_status    <= ST_SAT;
                        end else begin
                            o_out_value <= r_acc[31:0];
                            o_status    <= ST_OK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tcc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== tb/sv/table_connected_convolution_tb.sv =====
// Testbench for the table connected convolution block: loads pixels, weights,
// table entries and biases, reads output sums and checks them against a local predictor.
// Depends on tcc_pkg and the table_connected_convolution RTL.
`default_nettype none
module table_connected_convolution_tb;
    import tcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [2:0]         op;
        logic [5:0]         entry;
        logic [2:0]         in_plane;
        logic [3:0]         out_plane;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] value;
    } t_req;

    typedef struct {
        logic signed [31:0] sum;
        logic [1:0]         status;
    } t_sum;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_ready;
    logic [2:0] op_q = '0;
    logic [5:0] entry_q = '0;
    logic [2:0] in_plane_q = '0;
    logic [3:0] out_plane_q = '0;
    logic [4:0] row_q = '0;
    logic [4:0] col_q = '0;
    logic signed [31:0] value_q = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] o_out_value;
    logic [1:0] o_status;
    logic cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_req pending_items[$];
    t_sum expected_sums[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Local copy of the block state.
    logic signed [15:0] pix [MAX_IN_PLANES_D][MAX_DIM_D][MAX_DIM_D];
    bit pix_set [MAX_IN_PLANES_D][MAX_DIM_D][MAX_DIM_D];
    logic signed [15:0] wgt [MAX_TABLE_D][MAX_KERNEL_D][MAX_KERNEL_D];
    bit wgt_set [MAX_TABLE_D][MAX_KERNEL_D][MAX_KERNEL_D];
    logic [2:0] conn_src [MAX_TABLE_D];
    logic [3:0] conn_dst [MAX_TABLE_D];
    bit conn_set [MAX_TABLE_D];
    logic signed [31:0] bias [MAX_OUT_PLANES_D];
    bit bias_set [MAX_OUT_PLANES_D];
    int reg_ih = 32, reg_iw = 32, reg_kh = 5, reg_kw = 5, reg_ne = 0, reg_np = 1;

    table_connected_convolution DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_op(op_q), .i_entry(entry_q), .i_in_plane(in_plane_q),
        .i_out_plane(out_plane_q), .i_row(row_q), .i_col(col_q), .i_value(value_q),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_out_value(o_out_value), .o_status(o_status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic signed [15:0] sat_q88(logic signed [31:0] v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic bit outside_region(int plane, int row, int col);
        int ih, iw, kh, kw;
        ih = clamp(reg_ih, 1, MAX_DIM_D);
        iw = clamp(reg_iw, 1, MAX_DIM_D);
        kh = clamp(reg_kh, 1, MAX_KERNEL_D);
        kw = clamp(reg_kw, 1, MAX_KERNEL_D);
        return kh > ih || kw > iw || plane >= clamp(reg_np, 1, MAX_OUT_PLANES_D) ||
            row > ih - kh || col > iw - kw;
    endfunction

    // True when a read touches only store entries that were written.
    function automatic bit read_defined(int plane, int row, int col);
        int kh, kw, ne;
        kh = clamp(reg_kh, 1, MAX_KERNEL_D);
        kw = clamp(reg_kw, 1, MAX_KERNEL_D);
        ne = clamp(reg_ne, 0, MAX_TABLE_D);
        if (outside_region(plane, row, col)) return 1'b1;
        if (!bias_set[plane]) return 1'b0;
        for (int e = 0; e < ne; e++) begin
            if (!conn_set[e]) return 1'b0;
            if (conn_dst[e] != plane) continue;
            for (int i = 0; i < kh; i++)
                for (int j = 0; j < kw; j++)
                    if (!wgt_set[e][i][j] || !pix_set[conn_src[e]][row+i][col+j])
                        return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_sum apply_item(t_req r);
        t_sum res;
        longint acc;
        int kh, kw, ne;
        res.sum = '0;
        res.status = ST_RANGE;
        case (r.op)
            OP_PIXEL: begin
                pix[r.in_plane][r.row][r.col] = sat_q88(r.value);
                pix_set[r.in_plane][r.row][r.col] = 1'b1;
                res.status = ST_OK;
            end
            OP_WEIGHT: begin
                if (r.row < MAX_KERNEL_D && r.col < MAX_KERNEL_D) begin
                    wgt[r.entry][r.row][r.col] = sat_q88(r.value);
                    wgt_set[r.entry][r.row][r.col] = 1'b1;
                    res.status = ST_OK;
                end
            end
            OP_TABLE: begin
                conn_src[r.entry] = r.in_plane;
                conn_dst[r.entry] = r.out_plane;
                conn_set[r.entry] = 1'b1;
                res.status = ST_OK;
            end
            OP_BIAS: begin
                bias[r.out_plane] = r.value;
                bias_set[r.out_plane] = 1'b1;
                res.status = ST_OK;
            end
            OP_READ: begin
                if (!outside_region(r.out_plane, r.row, r.col)) begin
                    kh = clamp(reg_kh, 1, MAX_KERNEL_D);
                    kw = clamp(reg_kw, 1, MAX_KERNEL_D);
                    ne = clamp(reg_ne, 0, MAX_TABLE_D);
                    acc = bias[r.out_plane];
                    for (int e = 0; e < ne; e++) begin
                        if (conn_dst[e] != r.out_plane) continue;
                        for (int i = 0; i < kh; i++)
                            for (int j = 0; j < kw; j++)
                                acc += longint'(pix[conn_src[e]][r.row+i][r.col+j]) *
                                    longint'(wgt[e][i][j]);
                    end
                    res.status = ST_OK;
                    if (acc > 64'sd2147483647) begin
                        acc = 64'sd2147483647;
                        res.status = ST_SAT;
                    end else if (acc < -64'sd2147483648) begin
                        acc = -64'sd2147483648;
                        res.status = ST_SAT;
                    end
                    res.sum = acc[31:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic put(logic [2:0] op, int entry, int ip, int opl, int row, int col,
                       logic signed [31:0] value);
        t_req r;
        r.op = op;
        r.entry = 6'(entry);
        r.in_plane = 3'(ip);
        r.out_plane = 4'(opl);
        r.row = 5'(row);
        r.col = 5'(col);
        r.value = value;
        expected_sums.push_back(apply_item(r));
        pending_items.push_back(r);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(1023)) - 512;
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(65535)) - 32768;
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_sums.size() > 0 || in_valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int data);
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(data);
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IN_HEIGHT: reg_ih = data & 'h3f;
            CFG_IN_WIDTH: reg_iw = data & 'h3f;
            CFG_KERNEL_HEIGHT: reg_kh = data & 'hf;
            CFG_KERNEL_WIDTH: reg_kw = data & 'hf;
            CFG_TABLE_ENTRIES: reg_ne = data & 'h7f;
            default: reg_np = data & 'h1f;
        endcase
    endtask

    task automatic set_layer(int ih, int iw, int kh, int kw, int ne, int np);
        wait_idle();
        write_reg(CFG_IN_HEIGHT, ih);
        write_reg(CFG_IN_WIDTH, iw);
        write_reg(CFG_KERNEL_HEIGHT, kh);
        write_reg(CFG_KERNEL_WIDTH, kw);
        write_reg(CFG_TABLE_ENTRIES, ne);
        write_reg(CFG_OUT_PLANES, np);
    endtask

    task automatic put_read(int plane, int row, int col);
        if (read_defined(plane, row, col)) put(OP_READ, $urandom_range(63),
            $urandom_range(7), plane, row, col, $urandom);
        else put(OP_READ, $urandom_range(63), $urandom_range(7), plane, 31, col, $urandom);
    endtask

    task automatic put_noise();
        logic [2:0] op;
        op = 3'($urandom_range(7));
        if (op == OP_READ) put_read($urandom_range(15), $urandom_range(31),
            $urandom_range(31));
        else put(op, $urandom_range(63), $urandom_range(7), $urandom_range(15),
            $urandom_range(31), $urandom_range(31), rand_value());
    endtask

    task automatic random_layer(int n_items);
        int ih, iw, kh, kw, ne, np, e, pick;
        ih = $urandom_range(4, 2);
        iw = $urandom_range(4, 2);
        kh = $urandom_range(ih, 1);
        kw = $urandom_range(iw, 1);
        ne = $urandom_range(2, 1);
        np = $urandom_range(3, 1);
        set_layer(ih, iw, kh, kw, ne, np);
        for (int p = 0; p < np; p++) put(OP_BIAS, 0, 0, p, 0, 0, rand_value());
        for (e = 0; e < ne; e++) begin
            put(OP_TABLE, e, $urandom_range(7), $urandom_range(np - 1), 0, 0, 0);
            for (int i = 0; i < kh; i++)
                for (int j = 0; j < kw; j++) put(OP_WEIGHT, e, 0, 0, i, j, rand_value());
            for (int i = 0; i < ih; i++)
                for (int j = 0; j < iw; j++)
                    if (!pix_set[conn_src[e]][i][j] || $urandom_range(1))
                        put(OP_PIXEL, 0, conn_src[e], 0, i, j, rand_value());
        end
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 55) put_read($urandom_range(np - 1), $urandom_range(ih - kh),
                $urandom_range(iw - kw));
            else if (pick < 70) put(OP_PIXEL, 0, conn_src[$urandom_range(ne - 1)], 0,
                $urandom_range(ih - 1), $urandom_range(iw - 1), rand_value());
            else if (pick < 80) put(OP_WEIGHT, $urandom_range(ne - 1), 0, 0,
                $urandom_range(kh - 1), $urandom_range(kw - 1), rand_value());
            else if (pick < 85) put(OP_BIAS, 0, 0, $urandom_range(np - 1), 0, 0, rand_value());
            else put_noise();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest layer: every register at zero, sizes count as one.
        set_layer(0, 0, 0, 0, 0, 0);
        put(OP_BIAS, 0, 0, 0, 0, 0, 32'sd100);
        put(OP_READ, 0, 0, 0, 0, 0, 0);
        put(OP_READ, 0, 0, 1, 0, 0, 0);
        put(OP_READ, 0, 0, 0, 1, 0, 0);
        put(OP_READ, 0, 0, 0, 0, 1, 0);
        put(3'd5, 0, 0, 0, 0, 0, 0);
        put(3'd6, 63, 7, 15, 31, 31, -1);
        put(3'd7, 0, 0, 0, 0, 0, 0);
        put(OP_WEIGHT, 63, 0, 0, 8, 0, 5);
        put(OP_WEIGHT, 0, 0, 0, 0, 31, 5);
        put(OP_PIXEL, 0, 7, 0, 31, 31, 32'sh80000000);

        // One tap layer driven into saturation at both ends.
        set_layer(1, 1, 1, 1, 1, 1);
        put(OP_TABLE, 0, 0, 0, 0, 0, 0);
        put(OP_WEIGHT, 0, 0, 0, 0, 0, 32'sh7fffffff);
        put(OP_PIXEL, 0, 0, 0, 0, 0, 32'sh7fffffff);
        put(OP_BIAS, 0, 0, 0, 0, 0, 32'sh7fffffff);
        put(OP_READ, 0, 0, 0, 0, 0, 0);
        put(OP_PIXEL, 0, 0, 0, 0, 0, 32'sh80000000);
        put(OP_BIAS, 0, 0, 0, 0, 0, 32'sh80000000);
        put(OP_READ, 0, 0, 0, 0, 0, 0);
        put(OP_WEIGHT, 0, 0, 0, 0, 0, 32'sh80000000);
        put(OP_BIAS, 0, 0, 0, 0, 0, 32'sh7fffffff);
        put(OP_READ, 0, 0, 0, 0, 0, 0);
        put(OP_TABLE, 0, 0, 15, 0, 0, 0);
        put(OP_READ, 0, 0, 0, 0, 0, 0);

        // Registers above their ranges: reads outside the region, then random items.
        set_layer(127, 127, 127, 127, 127, 127);
        put(OP_READ, 0, 0, 15, 25, 0, 0);
        put(OP_READ, 0, 0, 0, 0, 25, 0);
        put(OP_READ, 0, 0, 31 % 16, 31, 31, 0);
        for (int n = 0; n < 10; n++) put_noise();

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 73 : 29) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 73 : 29) : 0;
            random_layer(6);
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("table_connected_convolution test passed");
        end else begin
            $display("table_connected_convolution test failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                op_q <= pending_items[0].op;
                entry_q <= pending_items[0].entry;
                in_plane_q <= pending_items[0].in_plane;
                out_plane_q <= pending_items[0].out_plane;
                row_q <= pending_items[0].row;
                col_q <= pending_items[0].col;
                value_q <= pending_items[0].value;
                void'(pending_items.pop_front());
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: value %0d status %0d", o_out_value, o_status);
            end else begin
                if (o_out_value !== expected_sums[0].sum ||
                    o_status !== expected_sums[0].status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected value %0d status %0d, got %0d status %0d",
                            expected_sums[0].sum, expected_sums[0].status,
                            o_out_value, o_status);
                end
                void'(expected_sums.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("table_connected_convolution test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/tcc_pkg.sv
rtl/tcc_ram.sv
rtl/table_connected_convolution.sv
tb/sv/table_connected_convolution_tb.sv
